// ===== rtl/core/sppl_pkg.sv =====
`default_nettype none
package sppl_pkg;

    localparam int MUL_AW = 34;   // signed multiplicand width
    localparam int MUL_BW = 16;   // unsigned multiplier width
    localparam int MUL_W  = 52;   // accumulator width
    localparam int DIV_W  = 52;   // dividend and quotient width
    localparam int DIV_DW = 16;   // divisor width
    localparam int MUL_CW = $clog2(MUL_BW);
    localparam int DIV_CW = $clog2(DIV_W);

    localparam int HALF_TURN = 18000;
    localparam int FULL_TURN = 36000;
    localparam logic [DIV_DW-1:0] PID_SCALE  = 16'd1000;
    localparam logic [DIV_DW-1:0] FILT_SCALE = 16'd10;

    typedef enum logic [2:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEG_GAIN    = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_INTEG_LIMIT   = 3'd3,
        REG_EFFORT_LIMIT  = 3'd4,
        REG_PHASE_ADVANCE = 3'd5,
        REG_STEP_ANGLE    = 3'd6,
        REG_NONE          = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic                     start;
        logic                     accum;
        logic signed [MUL_AW-1:0] a;
        logic [MUL_BW-1:0]        b;
    } mul_req_t;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [MUL_W-1:0] result;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] result;
    } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/sppl_mul.sv =====
`default_nettype none
module sppl_mul
    import sppl_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    // shift-and-add, one multiplier bit per cycle
    logic signed [MUL_W-1:0] a_reg;
    logic [MUL_BW-1:0]       b_reg;
    logic signed [MUL_W-1:0] acc_reg;
    logic [MUL_CW-1:0]       cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                a_reg    <= MUL_W'(req.a);
                b_reg    <= req.b;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
                if (!req.accum) begin
                    acc_reg <= '0;
                end
            end else if (busy_reg) begin
                if (b_reg[0]) begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg   <= a_reg <<< 1;
                b_reg   <= b_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CW'(MUL_BW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule
`default_nettype wire

// ===== rtl/core/sppl_div.sv =====
`default_nettype none
module sppl_div
    import sppl_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    // restoring division, one quotient bit per cycle
    logic [DIV_W-1:0]  dvd_reg;
    logic [DIV_DW-1:0] dvs_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   trial;
    logic              qbit;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                dvd_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (qbit) begin
                    rem_reg <= DIV_DW'(trial - {1'b0, dvs_reg});
                end else begin
                    rem_reg <= trial[DIV_DW-1:0];
                end
                dvd_reg <= {dvd_reg[DIV_W-2:0], qbit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = dvd_reg;

endmodule
`default_nettype wire

// ===== rtl/core/stepper_position_pid_loop.sv =====
`default_nettype none
// position control loop for a closed-loop stepper, one control tick per transaction
// s_ channel: one tick per transaction; tdata holds rotor_angle, step_cmd and
//   tune_effort, tuser holds loop_enabled and tune_active
// m_ channel: one result per tick with phase_angle, effort_magnitude,
//   new_step_cmd and the unwrapped position
// apb port: seven configuration registers at byte addresses 0 to 24, to be written
//   only while idle by the user; the block itself does not enforce this
// per tick: tuning uses neither arithmetic unit, a disabled loop takes two divider
//   passes and an enabled loop four multiplies and one divider pass
// one tick is worked at a time; s_tready is high only when the sequencer is idle,
//   set by the bit-serial multiplier and divider which each handle one bit a cycle
// results sit in an output register, so the next tick is taken while one waits;
//   a stalled receiver holds the finished tick until the register frees up
// reset clears the position, previous angle, error and integrator state and
//   loads the register defaults
module stepper_position_pid_loop
    import sppl_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [15:0] rotor_angle, [47:16] step_cmd, [64:48] tune_effort, rest zero
    input  wire logic [71:0]  s_tdata,
    // [0] loop_enabled, [1] tune_active
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [16:0] phase_angle, [32:17] effort_magnitude, [64:33] new_step_cmd,
    // [96:65] position, rest zero
    output logic [103:0]      m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_UNWRAP, S_MUL_R, S_ERR, S_MUL_P, S_MUL_I, S_MUL_D,
        S_DIV_U, S_DIV_Q, S_DIV_T, S_FINISH
    } state_t;

    // configuration registers
    logic [15:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [19:0] integ_limit_reg;
    logic [15:0] effort_limit_reg;
    logic [13:0] phase_advance_reg;
    logic [15:0] step_angle_reg;
    reg_idx_t    widx;

    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= 16'd1000;
            integ_gain_reg    <= 16'd100;
            deriv_gain_reg    <= 16'd0;
            integ_limit_reg   <= 20'd10000;
            effort_limit_reg  <= 16'd1000;
            phase_advance_reg <= 14'd9000;
            step_angle_reg    <= 16'd180;
        end else if (psel && penable && pwrite && pready) begin
            case (widx)
                REG_PROP_GAIN:     prop_gain_reg     <= pwdata[15:0];
                REG_INTEG_GAIN:    integ_gain_reg    <= pwdata[15:0];
                REG_DERIV_GAIN:    deriv_gain_reg    <= pwdata[15:0];
                REG_INTEG_LIMIT:   integ_limit_reg   <= pwdata[19:0];
                REG_EFFORT_LIMIT:  effort_limit_reg  <= pwdata[15:0];
                REG_PHASE_ADVANCE: phase_advance_reg <= pwdata[13:0];
                REG_STEP_ANGLE:    step_angle_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (widx)
            REG_PROP_GAIN:     prdata = {16'd0, prop_gain_reg};
            REG_INTEG_GAIN:    prdata = {16'd0, integ_gain_reg};
            REG_DERIV_GAIN:    prdata = {16'd0, deriv_gain_reg};
            REG_INTEG_LIMIT:   prdata = {12'd0, integ_limit_reg};
            REG_EFFORT_LIMIT:  prdata = {16'd0, effort_limit_reg};
            REG_PHASE_ADVANCE: prdata = {18'd0, phase_advance_reg};
            REG_STEP_ANGLE:    prdata = {16'd0, step_angle_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // serial arithmetic units
    mul_req_t mreq_reg;
    mul_rsp_t mrsp;
    div_req_t dreq_reg;
    div_rsp_t drsp;

    sppl_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mreq_reg), .rsp(mrsp));
    sppl_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq_reg), .rsp(drsp));

    // loop state and per-tick working registers
    state_t             state_reg;
    logic signed [31:0] pos_reg;
    logic [15:0]        prev_angle_reg;
    logic signed [31:0] prev_error_reg;
    logic signed [31:0] error_sum_reg;
    logic [15:0]        angle_reg;
    logic signed [31:0] tgt_reg;
    logic               enabled_reg, tuning_reg;
    logic signed [16:0] tune_reg;
    logic signed [31:0] e0_reg;
    logic signed [31:0] new_tgt_reg;
    logic               neg_reg;
    logic [15:0]        mag_reg;
    logic               upos_reg;
    logic               m_tvalid_reg;
    logic [103:0]       m_tdata_reg;

    // angle unwrap
    logic signed [17:0] diff_raw, diff_adj;
    logic signed [31:0] pos_next;

    assign diff_raw = $signed({2'b00, angle_reg}) - $signed({2'b00, prev_angle_reg});
    always_comb begin
        if (diff_raw < -18'sd18000) begin
            diff_adj = diff_raw + 18'(FULL_TURN);
        end else if (diff_raw > 18'(HALF_TURN)) begin
            diff_adj = diff_raw - 18'(FULL_TURN);
        end else begin
            diff_adj = diff_raw;
        end
    end
    assign pos_next = pos_reg + 32'(diff_adj);

    // integrator clamp
    logic signed [33:0] isum;
    logic signed [33:0] ilim;
    logic signed [31:0] iclamp;

    assign isum = 34'(error_sum_reg) + 34'(e0_reg);
    assign ilim = $signed({14'd0, integ_limit_reg});
    always_comb begin
        if (isum > ilim) begin
            iclamp = 32'(ilim);
        end else if (isum < -ilim) begin
            iclamp = 32'(-ilim);
        end else begin
            iclamp = 32'(isum);
        end
    end

    // derivative term
    logic signed [33:0] dterm;
    assign dterm = 34'(e0_reg) - 34'(prev_error_reg);

    // pid sum magnitude and effort clamp of the quotient
    logic signed [MUL_W-1:0] psum;
    logic [DIV_W-1:0]        psum_mag;
    assign psum     = mrsp.result;
    assign psum_mag = psum[MUL_W-1] ? DIV_W'(-psum) : DIV_W'(psum);

    logic [15:0] qmag;
    assign qmag = (drsp.result > DIV_W'(effort_limit_reg)) ? effort_limit_reg
                                                            : drsp.result[15:0];

    // tuning effort clamp
    logic [16:0] tmag;
    logic [15:0] tclamp;
    assign tmag   = tune_reg[16] ? 17'(-tune_reg) : 17'(tune_reg);
    assign tclamp = (tmag > {1'b0, effort_limit_reg}) ? effort_limit_reg : tmag[15:0];

    // target filter numerator: 9 * target + position / step_angle
    logic signed [32:0] qpos;
    logic signed [36:0] tgt37;
    logic signed [36:0] fnum;
    logic [DIV_W-1:0]   fnum_mag;
    assign qpos     = neg_reg ? -$signed({1'b0, drsp.result[31:0]})
                              : $signed({1'b0, drsp.result[31:0]});
    assign tgt37    = 37'(tgt_reg);
    assign fnum     = (tgt37 <<< 3) + tgt37 + 37'(qpos);
    assign fnum_mag = fnum[36] ? DIV_W'(-fnum) : DIV_W'(fnum);

    // coil phase
    logic [16:0] phase;
    always_comb begin
        if (upos_reg) begin
            phase = 17'd0 - {1'b0, angle_reg} - {3'd0, phase_advance_reg};
        end else begin
            phase = {3'd0, phase_advance_reg} - {1'b0, angle_reg};
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pos_reg        <= '0;
            prev_angle_reg <= '0;
            prev_error_reg <= '0;
            error_sum_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
            mreq_reg       <= '0;
            dreq_reg       <= '0;
        end else begin
            // start pulses last one cycle; no new start is issued while one is up
            if (mreq_reg.start) begin
                mreq_reg.start <= 1'b0;
            end
            if (dreq_reg.start) begin
                dreq_reg.start <= 1'b0;
            end
            // the finish step reloads the output register itself
            if (m_tvalid_reg && m_tready && state_reg != S_FINISH) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        angle_reg   <= s_tdata[15:0];
                        tgt_reg     <= s_tdata[47:16];
                        new_tgt_reg <= s_tdata[47:16];
                        tune_reg    <= s_tdata[64:48];
                        enabled_reg <= s_tuser[0];
                        tuning_reg  <= s_tuser[1];
                        state_reg   <= S_UNWRAP;
                    end
                end
                S_UNWRAP: begin
                    pos_reg        <= pos_next;
                    prev_angle_reg <= angle_reg;
                    if (tuning_reg) begin
                        mag_reg   <= tclamp;
                        upos_reg  <= !tune_reg[16] && (tclamp != 16'd0);
                        state_reg <= S_FINISH;
                    end else if (enabled_reg) begin
                        // reference position, wraps modulo 2^32
                        mreq_reg  <= '{start: 1'b1, accum: 1'b0,
                                       a: 34'(tgt_reg), b: step_angle_reg};
                        state_reg <= S_MUL_R;
                    end else begin
                        neg_reg   <= pos_next[31];
                        dreq_reg  <= '{start: 1'b1,
                                       dividend: pos_next[31] ? DIV_W'(-34'(pos_next))
                                                              : DIV_W'(pos_next),
                                       divisor: (step_angle_reg == 16'd0) ? 16'd1
                                                                          : step_angle_reg};
                        state_reg <= S_DIV_Q;
                    end
                end
                S_MUL_R: begin
                    if (mrsp.done) begin
                        e0_reg    <= mrsp.result[31:0] - pos_reg;
                        state_reg <= S_ERR;
                    end
                end
                S_ERR: begin
                    error_sum_reg <= iclamp;
                    mreq_reg      <= '{start: 1'b1, accum: 1'b0,
                                       a: 34'(e0_reg), b: prop_gain_reg};
                    state_reg     <= S_MUL_P;
                end
                S_MUL_P: begin
                    if (mrsp.done) begin
                        mreq_reg  <= '{start: 1'b1, accum: 1'b1,
                                       a: 34'(error_sum_reg), b: integ_gain_reg};
                        state_reg <= S_MUL_I;
                    end
                end
                S_MUL_I: begin
                    if (mrsp.done) begin
                        mreq_reg       <= '{start: 1'b1, accum: 1'b1,
                                            a: dterm, b: deriv_gain_reg};
                        prev_error_reg <= e0_reg;
                        state_reg      <= S_MUL_D;
                    end
                end
                S_MUL_D: begin
                    if (mrsp.done) begin
                        neg_reg   <= psum[MUL_W-1];
                        dreq_reg  <= '{start: 1'b1, dividend: psum_mag, divisor: PID_SCALE};
                        state_reg <= S_DIV_U;
                    end
                end
                S_DIV_U: begin
                    if (drsp.done) begin
                        mag_reg   <= qmag;
                        upos_reg  <= !neg_reg && (qmag != 16'd0);
                        state_reg <= S_FINISH;
                    end
                end
                S_DIV_Q: begin
                    if (drsp.done) begin
                        neg_reg   <= fnum[36];
                        dreq_reg  <= '{start: 1'b1, dividend: fnum_mag, divisor: FILT_SCALE};
                        state_reg <= S_DIV_T;
                    end
                end
                S_DIV_T: begin
                    if (drsp.done) begin
                        new_tgt_reg    <= neg_reg ? -drsp.result[31:0] : drsp.result[31:0];
                        error_sum_reg  <= '0;
                        prev_error_reg <= '0;
                        mag_reg        <= '0;
                        upos_reg       <= 1'b0;
                        state_reg      <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {7'd0, pos_reg, new_tgt_reg, mag_reg, phase};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // arithmetic units only run while the sequencer waits on them
    a_idle_units: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (!mrsp.busy && !drsp.busy))
        else $error("arithmetic unit busy while idle");

    a_mul_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mrsp.done |-> (state_reg == S_MUL_R || state_reg == S_MUL_P ||
                       state_reg == S_MUL_I || state_reg == S_MUL_D))
        else $error("multiplier finished outside a multiply step");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        drsp.done |-> (state_reg == S_DIV_U || state_reg == S_DIV_Q ||
                       state_reg == S_DIV_T))
        else $error("divider finished outside a divide step");

    a_finish_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && (!m_tvalid_reg || m_tready)) |=> m_tvalid_reg)
        else $error("finished tick not presented");

endmodule
`default_nettype wire
